/* rtl/pst_pkg.sv */
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, operation and status codes for the process slot table.
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int SLOTS_DEF   = 32;
	localparam int MAX_CPUS    = 64;

	localparam int PID_W       = 32;
	localparam int CPU_W       = 6;
	localparam int STATE_W     = 3;
	localparam int OP_W        = 3;
	localparam int STATUS_W    = 2;
	localparam int SLOT_IDX_W  = 5;
	localparam int CFG_W       = 7;
	localparam int CFG_IDX_W   = 1;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS) + 1;

	localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
	localparam logic [OP_W-1:0] OP_NEWEST = 3'd3;
	localparam logic [OP_W-1:0] OP_REAP   = 3'd4;
	localparam logic [OP_W-1:0] OP_SET    = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_CPUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZOMBIE_CODE = 1'd1;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [PID_W-1:0]   pid;
		logic [CPU_W-1:0]   affinity;
		logic [STATE_W-1:0] new_state;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_IDX_W-1:0] slot_index;
		logic [PID_W-1:0]      result_pid;
		logic [CPU_W-1:0]      result_affinity;
	} out_item_t;

	typedef struct packed {
		logic [PID_W-1:0]   id;
		logic [CPU_W-1:0]   cpu;
		logic [STATE_W-1:0] state;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic work_done;
		logic out_busy;
	} stat_t;

endpackage

/* rtl/pst_divider.sv */
// ----------------------------------------------------------------------------
// pst_divider
// Restoring remainder unit: rotor modulo CPU count, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pst_divider (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [pst_pkg::PID_W-1:0]        dividend,
	input  logic [pst_pkg::CFG_W-1:0]        divisor,
	output logic                             done,
	output logic [pst_pkg::CPU_W-1:0]        rem
);
	import pst_pkg::*;

	logic [CFG_W-1:0]     rem_q;
	logic [CFG_W-1:0]     n_q;
	logic [PID_W-1:0]     dvd_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [CFG_W:0]       shifted;
	logic [CFG_W:0]       trial;

	assign shifted = {rem_q, dvd_q[PID_W-1]};
	assign trial   = (shifted >= {1'b0, n_q}) ? (shifted - {1'b0, n_q}) : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			n_q   <= divisor;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= trial[CFG_W-1:0];
			dvd_q <= {dvd_q[PID_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	// remainder stays below the divisor, which is at most 64
	assign rem  = rem_q[CPU_W-1:0];

endmodule

/* rtl/pst_datapath.sv */
// ----------------------------------------------------------------------------
// pst_datapath
// Slot storage, linear scan with registered memory read, id and rotor
// counters, configuration registers and the result register.
// ----------------------------------------------------------------------------
module pst_datapath #(
	parameter int SLOTS = pst_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pst_pkg::cmd_t                   cmd,
	output pst_pkg::stat_t                  stat,
	input  pst_pkg::in_item_t               in_item,
	input  logic                            cfg_we,
	input  logic [pst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pst_pkg::CFG_W-1:0]       cfg_wdata,
	output pst_pkg::out_item_t              out_item,
	output logic                            out_valid,
	input  logic                            out_ready
);
	import pst_pkg::*;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = SLOT_W + 1;

	logic [CFG_W-1:0]   online_cpus_q;
	logic [STATE_W-1:0] zombie_code_q;
	logic [PID_W-1:0]   next_id_q;
	logic [PID_W-1:0]   rotor_q;
	logic [SLOTS-1:0]   used_q;
	in_item_t           item_q;

	entry_t             mem [SLOTS];
	entry_t             rd_s1;
	entry_t             wr_entry;
	logic               mem_we;

	logic [CNT_W-1:0]   cnt_q;
	logic [SLOT_W-1:0]  rd_addr;
	logic               valid_s1;
	logic               used_s1;
	logic [SLOT_W-1:0]  slot_s1;

	logic               found_q;
	logic [SLOT_W-1:0]  found_slot_q;
	logic [PID_W-1:0]   found_id_q;
	logic [CPU_W-1:0]   found_cpu_q;

	out_item_t          out_q;
	logic               out_valid_q;
	out_item_t          result;

	logic               is_create;
	logic               first_op;
	logic               issue;
	logic               eval;
	logic               match;
	logic               scan_done;
	logic               div_start;
	logic               div_done;
	logic [CPU_W-1:0]   div_rem;
	logic [CFG_W-1:0]   cpu_count;

	assign is_create = (item_q.operation == OP_CREATE);
	// newest must look at every slot; all other operations stop on first hit
	assign first_op  = (item_q.operation != OP_NEWEST);
	assign rd_addr   = cnt_q[SLOT_W-1:0];
	assign issue     = cmd.step && (cnt_q < CNT_W'(SLOTS)) && !(first_op && found_q);
	assign eval      = valid_s1 && !(first_op && found_q);
	assign scan_done = (first_op && found_q) || ((cnt_q == CNT_W'(SLOTS)) && !valid_s1);

	always_comb begin
		case (item_q.operation)
			OP_CREATE: match = !used_s1;
			OP_REMOVE,
			OP_FIND,
			OP_SET:    match = used_s1 && (rd_s1.id == item_q.pid);
			OP_NEWEST: match = used_s1 && (rd_s1.id > found_id_q);
			OP_REAP:   match = used_s1 && (rd_s1.state == zombie_code_q)
				&& (rd_s1.cpu == item_q.affinity);
			default:   match = 1'b0;
		endcase
	end

	// zero CPUs counts as one; saturate at the supported maximum
	always_comb begin
		if (online_cpus_q == '0)
			cpu_count = CFG_W'(1);
		else if (online_cpus_q > CFG_W'(MAX_CPUS))
			cpu_count = CFG_W'(MAX_CPUS);
		else
			cpu_count = online_cpus_q;
	end

	assign div_start = cmd.start && (in_item.operation == OP_CREATE);

	pst_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rotor_q),
		.divisor  (cpu_count),
		.done     (div_done),
		.rem      (div_rem)
	);

	// configuration, counters, used bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			online_cpus_q <= CFG_W'(1);
			zombie_code_q <= STATE_W'(4);
			next_id_q     <= PID_W'(1);
			rotor_q       <= '0;
			used_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ONLINE_CPUS: online_cpus_q <= cfg_wdata;
					CFG_ZOMBIE_CODE: zombie_code_q <= cfg_wdata[STATE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.commit) begin
				if (is_create) begin
					next_id_q <= next_id_q + 1'b1;
					rotor_q   <= rotor_q + 1'b1;
				end
				if (found_q) begin
					if (is_create)
						used_q[found_slot_q] <= 1'b1;
					else if (item_q.operation == OP_REMOVE || item_q.operation == OP_REAP)
						used_q[found_slot_q] <= 1'b0;
				end
			end
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else if (cmd.start) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			valid_s1 <= issue;
			if (issue)
				cnt_q <= cnt_q + 1'b1;
			if (eval && match)
				found_q <= 1'b1;
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (cmd.start)
			item_q <= in_item;
		used_s1 <= used_q[rd_addr];
		slot_s1 <= rd_addr;
		if (cmd.start) begin
			found_id_q <= '0;
		end else if (eval && match) begin
			found_slot_q <= slot_s1;
			found_id_q   <= rd_s1.id;
			found_cpu_q  <= rd_s1.cpu;
		end
	end

	// slot memory: one write port, one registered read port
	assign mem_we = cmd.commit && found_q && (is_create || item_q.operation == OP_SET);

	always_comb begin
		wr_entry.id    = is_create ? next_id_q : found_id_q;
		wr_entry.cpu   = is_create ? div_rem : found_cpu_q;
		wr_entry.state = item_q.new_state;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[found_slot_q] <= wr_entry;
		rd_s1 <= mem[rd_addr];
	end

	// result
	always_comb begin
		if (found_q) begin
			result.status          = ST_OK;
			result.slot_index      = SLOT_IDX_W'(found_slot_q);
			result.result_pid      = is_create ? next_id_q : found_id_q;
			result.result_affinity = is_create ? div_rem : found_cpu_q;
		end else begin
			result.status          = is_create ? ST_FULL : ST_NOTFOUND;
			result.slot_index      = '0;
			result.result_pid      = '0;
			result.result_affinity = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.commit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit)
			out_q <= result;
	end

	assign out_item       = out_q;
	assign out_valid      = out_valid_q;
	assign stat.out_busy  = out_valid_q && !out_ready;
	assign stat.work_done = scan_done && (!is_create || div_done);

endmodule

/* rtl/pst_ctrl.sv */
// ----------------------------------------------------------------------------
// pst_ctrl
// Sequencer: accept a beat, run the slot scan, commit when the result
// register is free.
// ----------------------------------------------------------------------------
module pst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pst_pkg::stat_t  stat,
	output pst_pkg::cmd_t   cmd
);
	import pst_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready   = (state_q == S_IDLE);
	assign cmd.start  = in_valid && in_ready;
	assign cmd.step   = (state_q == S_SCAN);
	assign cmd.commit = (state_q == S_COMMIT) && !stat.out_busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (cmd.start) state_d = S_SCAN;
			S_SCAN:   if (stat.work_done) state_d = S_COMMIT;
			S_COMMIT: if (!stat.out_busy) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* rtl/process_slot_table_top.sv */
// ----------------------------------------------------------------------------
// process_slot_table_top
// Process slot table: create, remove, find, newest, reap and set state over
// a fixed set of slots, one result beat per input beat.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------
//  in      | in_valid / in_ready  | in_item  (operation, pid, ...)
//  out     | out_valid / out_ready| out_item (status, slot, ...)
//  cfg     | cfg_we               | cfg_index, cfg_wdata
//
//  The scan reads one slot a cycle through the slot memory's single read port
//  and stops at the first hit (newest and misses read every slot); create also
//  waits for the 32-step remainder unit. The controller is ready for the next
//  beat as the result loads. Reset clears the used bits, id and rotor counters
//  and valid flags and loads the configuration defaults; slot memory and
//  payload registers are not reset. A held result stalls the commit.
// ----------------------------------------------------------------------------
module process_slot_table_top #(
	parameter int SLOTS = pst_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  pst_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output pst_pkg::out_item_t              out_item,
	input  logic                            cfg_we,
	input  logic [pst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pst_pkg::CFG_W-1:0]       cfg_wdata
);
	import pst_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pst_datapath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

`ifndef ASSERT_OFF
	a_commit_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("commit did not produce a result beat");

	a_idle_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!cmd.step && !cmd.commit))
		else $error("scan or commit while accepting");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !in_ready)
		else $error("accepted a beat without leaving idle");
`endif

endmodule
